// File: rtl/core/upd_pkg.sv
`timescale 1ns / 1ps
// upd_pkg: types, character codes and the hex digit helper for the URL percent decoder.
// Standalone; used by upd_step, upd_out_reg and url_percent_decoder.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CASE_GAP   = 8'h20;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  typedef enum logic [1:0] {
    PH_PLAIN   = 2'd0,
    PH_PERCENT = 2'd1,
    PH_HELD    = 2'd2
  } upd_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } upd_result_t;

  typedef struct packed {
    logic        emit;
    upd_result_t result;
    upd_phase_t  phase_nxt;
    logic [7:0]  held_nxt;
  } upd_step_t;

  // Hex value of one character, wrapping mod 256 for non-hex input.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      return c - CH_ZERO;
    end
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      lc = c + CASE_GAP;
    end
    return lc - CH_LOWER_A + HEX_TEN;
  endfunction

endpackage

// File: rtl/core/upd_step.sv
`timescale 1ns / 1ps
// upd_step: combinational decode of one byte against the current escape state.
// Depends on upd_pkg.
module upd_step (
  input  upd_pkg::upd_phase_t phase,
  input  logic [7:0]          held,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output upd_pkg::upd_step_t  step
);
  import upd_pkg::*;

  logic        plain_emit;
  upd_result_t plain_res;
  upd_phase_t  plain_phase;
  logic [7:0]  hex_hi;
  logic [7:0]  hex_lo;

  // Plain-text handling, also used for the final byte after a '%'
  always_comb begin
    plain_res   = '{data: 8'd0, byte_valid: 1'b0, last: in_last};
    plain_emit  = 1'b1;
    plain_phase = PH_PLAIN;
    if (in_data == CH_PERCENT) begin
      if (in_last) begin
        plain_res.last = 1'b1;
      end else begin
        plain_emit  = 1'b0;
        plain_phase = PH_PERCENT;
      end
    end else if (in_data == CH_PLUS) begin
      plain_res.data       = CH_SPACE;
      plain_res.byte_valid = 1'b1;
    end else begin
      plain_res.data       = in_data;
      plain_res.byte_valid = 1'b1;
    end
  end

  assign hex_hi = hex_value(held);
  assign hex_lo = hex_value(in_data);

  always_comb begin
    step.emit      = plain_emit;
    step.result    = plain_res;
    step.phase_nxt = plain_phase;
    step.held_nxt  = held;
    case (phase)
      PH_PERCENT: begin
        step.held_nxt = in_data;
        if (!in_last) begin
          step.emit      = 1'b0;
          step.phase_nxt = PH_HELD;
        end
      end
      PH_HELD: begin
        // low value ORed in unmasked
        step.emit      = 1'b1;
        step.result    = '{data: {hex_hi[3:0], 4'b0000} | hex_lo,
                           byte_valid: 1'b1, last: in_last};
        step.phase_nxt = PH_PLAIN;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/upd_out_reg.sv
`timescale 1ns / 1ps
// upd_out_reg: result register with valid/ready hand-off to the output channel.
// Depends on upd_pkg.
module upd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  upd_pkg::upd_result_t load_data,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output upd_pkg::upd_result_t out_data
);
  import upd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  upd_result_t data_r;

  // free when empty or draining this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/core/url_percent_decoder.sv
`timescale 1ns / 1ps
// url_percent_decoder: URL percent decoder, one encoded word in, at most one decoded word out.
// Path: a result passes from the input register through the decode step into the result register.
// Throughput: one word per cycle sustained while out_ready holds; set by the single decode step between
// the input register and the result register.
// Reset (rst_n, synchronous, active low) empties both registers and returns to plain text.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);
  import upd_pkg::*;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Escape state: phase and the first character after a '%'
  upd_phase_t phase_r;
  logic [7:0] held_r;

  upd_step_t   step;
  upd_result_t res;
  logic        can_load;
  logic        advance;
  logic        load;

  upd_step u_step (
    .phase   (phase_r),
    .held    (held_r),
    .in_data (in_byte_r),
    .in_last (in_last_r),
    .step    (step)
  );

  // A held word advances when it emits nothing, or when the result register
  // can take its result. Escape state moves only on advance.
  assign advance  = in_valid_r && (!step.emit || can_load);
  assign load     = advance && step.emit;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_PLAIN;
      held_r     <= 8'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        phase_r <= step.phase_nxt;
        held_r  <= step.held_nxt;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  upd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (step.result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_byte       = res.data;
  assign out_byte_valid = res.byte_valid;
  assign out_last       = res.last;

endmodule
